>>> hdl/rgbhsv_pkg.sv
// Shared types and constants for the RGB to HSV pixel converter.
// No dependencies; every other file in hdl/ refers to this package by scoped name.
package rgbhsv_pkg;

    localparam int CH_W          = 8;
    localparam int HUE_W         = 15;
    localparam int SAT_W         = 9;
    localparam int VAL_W         = 8;
    localparam int FRAC_BITS_DEF = 6;

    // Saturation divider: dividend is (max - min) * 256, quotient is at most 256.
    localparam int SAT_NUM_W = CH_W + 8;
    localparam int SAT_Q_W   = SAT_W;

    // Which channel holds the maximum, in tie order.
    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    // Per-pixel information that rides alongside the divider words.
    typedef struct packed {
        logic [VAL_W-1:0] val;
        sector_t          sector;
        logic             neg;
        logic             hue_zero;
        logic             sat_zero;
    } rgbhsv_side_t;

endpackage

>>> hdl/rgbhsv_prep.sv
// Front end of the converter: max/min search, channel differences and divider operands.
// Two register stages with valid/ready flow control; uses rgbhsv_pkg.
module rgbhsv_prep #(
    parameter int FRAC_BITS = rgbhsv_pkg::FRAC_BITS_DEF,
    parameter int NHW       = FRAC_BITS + 14
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [rgbhsv_pkg::CH_W-1:0]        red,
    input  logic [rgbhsv_pkg::CH_W-1:0]        green,
    input  logic [rgbhsv_pkg::CH_W-1:0]        blue,
    output logic                               dn_valid,
    input  logic                               dn_ready,
    output logic [NHW-1:0]                     hue_num,
    output logic [rgbhsv_pkg::CH_W-1:0]        hue_den,
    output logic [rgbhsv_pkg::SAT_NUM_W-1:0]   sat_num,
    output logic [rgbhsv_pkg::CH_W-1:0]        sat_den,
    output rgbhsv_pkg::rgbhsv_side_t           side
);

    localparam logic [NHW-1:0] SIXTY = NHW'(60) << FRAC_BITS;

    // Stage one: maximum, minimum and the signed difference of the other two channels.
    logic                           v1_reg;
    logic                           rdy1;
    logic [rgbhsv_pkg::CH_W-1:0]    mx_reg, mx_next;
    logic [rgbhsv_pkg::CH_W-1:0]    mn_reg, mn_next;
    logic signed [rgbhsv_pkg::CH_W:0] dif_reg, dif_next;
    rgbhsv_pkg::sector_t            sec_reg, sec_next;

    // Stage two registers.
    logic                           v2_reg;
    logic                           rdy2;
    logic [NHW-1:0]                 hn_reg, hn_next;
    logic [rgbhsv_pkg::CH_W-1:0]    hd_reg, hd_next;
    logic [rgbhsv_pkg::SAT_NUM_W-1:0] sn_reg, sn_next;
    logic [rgbhsv_pkg::CH_W-1:0]    sd_reg, sd_next;
    rgbhsv_pkg::rgbhsv_side_t       side_reg, side_next;
    logic [rgbhsv_pkg::CH_W:0]      mag;

    assign rdy2     = !v2_reg || dn_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb
    begin
        if (red >= green && red >= blue)
        begin
            mx_next  = red;
            sec_next = rgbhsv_pkg::SECT_RED;
            dif_next = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
        else if (green >= blue)
        begin
            mx_next  = green;
            sec_next = rgbhsv_pkg::SECT_GREEN;
            dif_next = $signed({1'b0, blue}) - $signed({1'b0, red});
        end
        else
        begin
            mx_next  = blue;
            sec_next = rgbhsv_pkg::SECT_BLUE;
            dif_next = $signed({1'b0, red}) - $signed({1'b0, green});
        end
        mn_next = red;
        if (green < mn_next)
        begin
            mn_next = green;
        end
        if (blue < mn_next)
        begin
            mn_next = blue;
        end
    end

    always_comb
    begin
        mag                = dif_reg[rgbhsv_pkg::CH_W] ? 9'(-dif_reg) : 9'(dif_reg);
        hd_next            = mx_reg - mn_reg;
        hn_next            = NHW'(mag[rgbhsv_pkg::CH_W-1:0]) * SIXTY;
        sn_next            = {hd_next, 8'b0};
        sd_next            = mx_reg;
        side_next.val      = mx_reg;
        side_next.sector   = sec_reg;
        side_next.neg      = dif_reg[rgbhsv_pkg::CH_W];
        side_next.hue_zero = (mx_reg == mn_reg);
        side_next.sat_zero = (mx_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            mx_reg  <= mx_next;
            mn_reg  <= mn_next;
            dif_reg <= dif_next;
            sec_reg <= sec_next;
        end
        if (rdy2 && v1_reg)
        begin
            hn_reg   <= hn_next;
            hd_reg   <= hd_next;
            sn_reg   <= sn_next;
            sd_reg   <= sd_next;
            side_reg <= side_next;
        end
    end

    assign dn_valid = v2_reg;
    assign hue_num  = hn_reg;
    assign hue_den  = hd_reg;
    assign sat_num  = sn_reg;
    assign sat_den  = sd_reg;
    assign side     = side_reg;

endmodule

>>> hdl/rgbhsv_div_step.sv
// One stage of the two restoring dividers: resolves a hue and/or a saturation quotient bit.
// Registered stage with valid/ready flow control; uses rgbhsv_pkg.
module rgbhsv_div_step #(
    parameter int NHW     = rgbhsv_pkg::FRAC_BITS_DEF + 14,
    parameter int QHW     = rgbhsv_pkg::FRAC_BITS_DEF + 6,
    parameter int HUE_BIT = 0,
    parameter bit HUE_ON  = 1'b1,
    parameter int SAT_BIT = 0,
    parameter bit SAT_ON  = 1'b1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               up_valid,
    output logic                               up_ready,
    input  logic [NHW-1:0]                     hn_in,
    input  logic [rgbhsv_pkg::CH_W-1:0]        hd_in,
    input  logic [QHW-1:0]                     hq_in,
    input  logic [rgbhsv_pkg::SAT_NUM_W-1:0]   sn_in,
    input  logic [rgbhsv_pkg::CH_W-1:0]        sd_in,
    input  logic [rgbhsv_pkg::SAT_Q_W-1:0]     sq_in,
    input  rgbhsv_pkg::rgbhsv_side_t           side_in,
    output logic                               dn_valid,
    input  logic                               dn_ready,
    output logic [NHW-1:0]                     hn_out,
    output logic [rgbhsv_pkg::CH_W-1:0]        hd_out,
    output logic [QHW-1:0]                     hq_out,
    output logic [rgbhsv_pkg::SAT_NUM_W-1:0]   sn_out,
    output logic [rgbhsv_pkg::CH_W-1:0]        sd_out,
    output logic [rgbhsv_pkg::SAT_Q_W-1:0]     sq_out,
    output rgbhsv_pkg::rgbhsv_side_t           side_out
);

    logic                             v_reg;
    logic [NHW-1:0]                   hn_reg, hn_next;
    logic [rgbhsv_pkg::CH_W-1:0]      hd_reg;
    logic [QHW-1:0]                   hq_reg, hq_next;
    logic [rgbhsv_pkg::SAT_NUM_W-1:0] sn_reg, sn_next;
    logic [rgbhsv_pkg::CH_W-1:0]      sd_reg;
    logic [rgbhsv_pkg::SAT_Q_W-1:0]   sq_reg, sq_next;
    rgbhsv_pkg::rgbhsv_side_t         side_reg;
    logic [NHW-1:0]                   hsh;
    logic [rgbhsv_pkg::SAT_NUM_W-1:0] ssh;

    assign up_ready = !v_reg || dn_ready;

    // Trial subtraction of the divisor aligned to this stage's quotient bit.
    always_comb
    begin
        hsh     = NHW'(hd_in) << HUE_BIT;
        ssh     = rgbhsv_pkg::SAT_NUM_W'(sd_in) << SAT_BIT;
        hn_next = hn_in;
        hq_next = hq_in;
        sn_next = sn_in;
        sq_next = sq_in;
        if (HUE_ON && hn_in >= hsh)
        begin
            hn_next          = hn_in - hsh;
            hq_next[HUE_BIT] = 1'b1;
        end
        if (SAT_ON && sn_in >= ssh)
        begin
            sn_next          = sn_in - ssh;
            sq_next[SAT_BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            hn_reg   <= hn_next;
            hd_reg   <= hd_in;
            hq_reg   <= hq_next;
            sn_reg   <= sn_next;
            sd_reg   <= sd_in;
            sq_reg   <= sq_next;
            side_reg <= side_in;
        end
    end

    assign dn_valid = v_reg;
    assign hn_out   = hn_reg;
    assign hd_out   = hd_reg;
    assign hq_out   = hq_reg;
    assign sn_out   = sn_reg;
    assign sd_out   = sd_reg;
    assign sq_out   = sq_reg;
    assign side_out = side_reg;

endmodule

>>> hdl/rgbhsv_post.sv
// Back end of the converter: sector offset, sign, wrap and the special cases, into the output register.
// Registered stage with valid/ready flow control; uses rgbhsv_pkg.
module rgbhsv_post #(
    parameter int FRAC_BITS = rgbhsv_pkg::FRAC_BITS_DEF,
    parameter int QHW       = FRAC_BITS + 6
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               up_valid,
    output logic                               up_ready,
    input  logic [QHW-1:0]                     hq_in,
    input  logic [rgbhsv_pkg::SAT_Q_W-1:0]     sq_in,
    input  rgbhsv_pkg::rgbhsv_side_t           side_in,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [rgbhsv_pkg::HUE_W-1:0]       hue,
    output logic [rgbhsv_pkg::SAT_W-1:0]       saturation,
    output logic [rgbhsv_pkg::VAL_W-1:0]       brightness
);

    localparam int HCW = FRAC_BITS + 10;
    localparam int HXW = (HCW > rgbhsv_pkg::HUE_W) ? HCW : rgbhsv_pkg::HUE_W;
    localparam logic signed [HCW-1:0] OFS_GREEN = HCW'(120) << FRAC_BITS;
    localparam logic signed [HCW-1:0] OFS_BLUE  = HCW'(240) << FRAC_BITS;
    localparam logic signed [HCW-1:0] FULL_TURN = HCW'(360) << FRAC_BITS;

    logic                            v_reg;
    logic [rgbhsv_pkg::HUE_W-1:0]    hue_reg, hue_next;
    logic [rgbhsv_pkg::SAT_W-1:0]    sat_reg, sat_next;
    logic [rgbhsv_pkg::VAL_W-1:0]    val_reg;
    logic signed [HCW-1:0]           ofs;
    logic signed [HCW-1:0]           qs;
    logic signed [HCW-1:0]           sum;
    logic [HXW-1:0]                  hx;

    assign up_ready = !v_reg || out_ready;

    always_comb
    begin
        unique case (side_in.sector)
            rgbhsv_pkg::SECT_RED:   ofs = '0;
            rgbhsv_pkg::SECT_GREEN: ofs = OFS_GREEN;
            rgbhsv_pkg::SECT_BLUE:  ofs = OFS_BLUE;
            default:                ofs = '0;
        endcase
        qs  = $signed(HCW'(hq_in));
        sum = side_in.neg ? (ofs - qs) : (ofs + qs);
        if (sum < 0)
        begin
            sum = sum + FULL_TURN;
        end
        hx       = HXW'($unsigned(sum));
        hue_next = side_in.hue_zero ? '0 : hx[rgbhsv_pkg::HUE_W-1:0];
        sat_next = side_in.sat_zero ? '0 : sq_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= side_in.val;
        end
    end

    assign out_valid  = v_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = val_reg;

endmodule

>>> hdl/rgb_to_hsv_pixel.sv
// RGB to HSV pixel converter, top level; builds on rgbhsv_pkg, rgbhsv_prep, rgbhsv_div_step, rgbhsv_post.
// Data passes the front end, the divider chain and the back end, each with valid/ready flow control.
// One pixel per cycle unless out_ready is low; the depth is set by the longer one-bit-per-stage divider.
// Reset (rst_n, asynchronous, active low) clears every stage's valid bit; data registers are not reset.
module rgb_to_hsv_pixel #(
    parameter int FRAC_BITS = rgbhsv_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rgbhsv_pkg::CH_W-1:0]   red,
    input  logic [rgbhsv_pkg::CH_W-1:0]   green,
    input  logic [rgbhsv_pkg::CH_W-1:0]   blue,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rgbhsv_pkg::HUE_W-1:0]  hue,
    output logic [rgbhsv_pkg::SAT_W-1:0]  saturation,
    output logic [rgbhsv_pkg::VAL_W-1:0]  brightness
);

    // The hue quotient is 60 * |difference| / (max - min), below 64 << FRAC_BITS,
    // so it needs FRAC_BITS + 6 bits. Its dividend needs 8 more bits for the difference.
    // Saturation needs nine quotient bits. Both dividers share one chain of stages,
    // each stage resolving at most one bit of each quotient, most significant bit first.
    localparam int QHW = FRAC_BITS + 6;
    localparam int NHW = FRAC_BITS + 14;
    localparam int NST = (QHW > rgbhsv_pkg::SAT_Q_W) ? QHW : rgbhsv_pkg::SAT_Q_W;

    // Chain signals; entry k feeds divider stage k, entry NST feeds the back end.
    logic                             v_ch   [0:NST];
    logic                             r_ch   [0:NST];
    logic [NHW-1:0]                   hn_ch  [0:NST];
    logic [rgbhsv_pkg::CH_W-1:0]      hd_ch  [0:NST];
    logic [QHW-1:0]                   hq_ch  [0:NST];
    logic [rgbhsv_pkg::SAT_NUM_W-1:0] sn_ch  [0:NST];
    logic [rgbhsv_pkg::CH_W-1:0]      sd_ch  [0:NST];
    logic [rgbhsv_pkg::SAT_Q_W-1:0]   sq_ch  [0:NST];
    rgbhsv_pkg::rgbhsv_side_t         sd_side[0:NST];

    // Front end: two stages that find the maximum channel, the sector and
    // the operands of both divisions.
    rgbhsv_prep #(
        .FRAC_BITS (FRAC_BITS),
        .NHW       (NHW)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .dn_valid (v_ch[0]),
        .dn_ready (r_ch[0]),
        .hue_num  (hn_ch[0]),
        .hue_den  (hd_ch[0]),
        .sat_num  (sn_ch[0]),
        .sat_den  (sd_ch[0]),
        .side     (sd_side[0])
    );

    // Quotients start at zero and collect at most one bit per stage.
    assign hq_ch[0] = '0;
    assign sq_ch[0] = '0;

    // Divider chain. Once a divider has resolved all its bits, the later
    // stages only carry its quotient along.
    for (genvar k = 0; k < NST; k++)
    begin : g_div
        localparam bit HON = (k < QHW);
        localparam bit SON = (k < rgbhsv_pkg::SAT_Q_W);
        localparam int HB  = HON ? (QHW - 1 - k) : 0;
        localparam int SB  = SON ? (rgbhsv_pkg::SAT_Q_W - 1 - k) : 0;

        rgbhsv_div_step #(
            .NHW     (NHW),
            .QHW     (QHW),
            .HUE_BIT (HB),
            .HUE_ON  (HON),
            .SAT_BIT (SB),
            .SAT_ON  (SON)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (v_ch[k]),
            .up_ready (r_ch[k]),
            .hn_in    (hn_ch[k]),
            .hd_in    (hd_ch[k]),
            .hq_in    (hq_ch[k]),
            .sn_in    (sn_ch[k]),
            .sd_in    (sd_ch[k]),
            .sq_in    (sq_ch[k]),
            .side_in  (sd_side[k]),
            .dn_valid (v_ch[k+1]),
            .dn_ready (r_ch[k+1]),
            .hn_out   (hn_ch[k+1]),
            .hd_out   (hd_ch[k+1]),
            .hq_out   (hq_ch[k+1]),
            .sn_out   (sn_ch[k+1]),
            .sd_out   (sd_ch[k+1]),
            .sq_out   (sq_ch[k+1]),
            .side_out (sd_side[k+1])
        );
    end

    // Back end: applies the sector offset and the sign of the hue term, wraps
    // negative hue by a full turn, forces hue to zero for gray and black pixels
    // and saturation to zero for black ones, and holds the output transaction.
    // The remainders left in the last chain entry are not needed.
    rgbhsv_post #(
        .FRAC_BITS (FRAC_BITS),
        .QHW       (QHW)
    ) u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (v_ch[NST]),
        .up_ready   (r_ch[NST]),
        .hq_in      (hq_ch[NST]),
        .sq_in      (sq_ch[NST]),
        .side_in    (sd_side[NST]),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

endmodule
